// ----- rtl/core/nrte_pkg.sv -----
// ----------------------------------------------------------------------------
// nrte_pkg
// Shared types, codes and character tables for the RMC time extractor.
// ----------------------------------------------------------------------------
package nrte_pkg;

    localparam int CHAR_W   = 8;
    localparam int HOURS_W  = 5;
    localparam int TIME_W   = 7;
    localparam int KIND_W   = 3;
    localparam int ZONE_W   = 5;

    localparam logic [ZONE_W-1:0] ZONE_RESET = 5'd8;
    localparam logic [7:0]        HOURS_PER_DAY = 8'd24;

    // token kind codes
    localparam logic [KIND_W-1:0] KIND_OTHER    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_SUM  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FIX  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END      = 3'd4;

    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_E      = 8'h45;
    localparam logic [CHAR_W-1:0] CH_V      = 8'h56;

    localparam logic [2:0] RMC_LEN = 3'd6;
    localparam logic [2:0] END_LEN = 3'd3;

    // one finished token handed from the front end to the back end
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] hours;
        logic [TIME_W-1:0] minutes;
        logic [TIME_W-1:0] seconds;
    } nrte_token_t;

    function automatic logic [CHAR_W-1:0] rmc_char(input logic [2:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            3'd0:    ch = 8'h24; // $
            3'd1:    ch = 8'h47; // G
            3'd2:    ch = 8'h50; // P
            3'd3:    ch = 8'h52; // R
            3'd4:    ch = 8'h4D; // M
            3'd5:    ch = 8'h43; // C
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] end_char(input logic [2:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            3'd0:    ch = 8'h45; // E
            3'd1:    ch = 8'h4E; // N
            3'd2:    ch = 8'h44; // D
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/nrte_front.sv -----
// ----------------------------------------------------------------------------
// nrte_front
// Per-character token parser; emits one token record at each token end.
// ----------------------------------------------------------------------------
module nrte_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [nrte_pkg::CHAR_W-1:0] s_char_byte,
    input  logic                       q_full,
    output logic                       q_push,
    output nrte_pkg::nrte_token_t      q_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RMC_PREFIX,
        PH_END_PREFIX,
        PH_BODY,
        PH_CHECK,
        PH_OTHER,
        PH_ENDTOK,
        PH_REJECT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  prefix_pos_reg, prefix_pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic [1:0]  comma_reg, comma_next;
    logic [2:0]  digit_pos_reg, digit_pos_next;
    logic [6:0]  cand_h_reg, cand_h_next;
    logic [6:0]  cand_m_reg, cand_m_next;
    logic [6:0]  cand_s_reg, cand_s_next;
    logic [7:0]  check_reg, check_next;
    logic [1:0]  check_cnt_reg, check_cnt_next;

    logic        accept;
    logic        is_ws;
    logic [7:0]  c;
    logic [3:0]  digit;
    logic [7:0]  digit_x10;
    logic [6:0]  slot_val;
    logic [6:0]  slot_new;
    logic [1:0]  comma_mid;
    logic [3:0]  hex_val;
    logic        hex_ok;
    logic [2:0]  kind;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign c       = s_char_byte;
    assign is_ws   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);

    assign digit     = c[3:0];
    assign digit_x10 = {1'b0, digit, 3'b000} + {3'b000, digit, 1'b0};

    always_comb begin
        if (digit_pos_reg < 3'd2) begin
            slot_val = cand_h_reg;
        end else if (digit_pos_reg < 3'd4) begin
            slot_val = cand_m_reg;
        end else begin
            slot_val = cand_s_reg;
        end
        if (!digit_pos_reg[0]) begin
            slot_new = digit_x10[6:0];
        end else begin
            slot_new = slot_val + {3'b000, digit};
        end
    end

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_val = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            hex_val = c[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        case (phase_reg)
            PH_BODY:   kind = nrte_pkg::KIND_BAD_SUM;
            PH_CHECK:  kind = (check_cnt_reg == 2'd2 && check_reg == xor_reg)
                              ? nrte_pkg::KIND_ACCEPTED : nrte_pkg::KIND_BAD_SUM;
            PH_ENDTOK: kind = nrte_pkg::KIND_END;
            PH_REJECT: kind = nrte_pkg::KIND_NOT_FIX;
            default:   kind = nrte_pkg::KIND_OTHER;
        endcase
    end

    assign q_data.kind    = kind;
    assign q_data.hours   = cand_h_reg;
    assign q_data.minutes = cand_m_reg;
    assign q_data.seconds = cand_s_reg;

    always_comb begin
        phase_next      = phase_reg;
        prefix_pos_next = prefix_pos_reg;
        xor_next        = xor_reg;
        comma_next      = comma_reg;
        digit_pos_next  = digit_pos_reg;
        cand_h_next     = cand_h_reg;
        cand_m_next     = cand_m_reg;
        cand_s_next     = cand_s_reg;
        check_next      = check_reg;
        check_cnt_next  = check_cnt_reg;
        q_push          = 1'b0;
        comma_mid       = comma_reg;

        if (accept) begin
            if (is_ws) begin
                if (phase_reg != PH_IDLE) begin
                    q_push          = 1'b1;
                    phase_next      = PH_IDLE;
                    prefix_pos_next = 3'd0;
                    xor_next        = 8'd0;
                    comma_next      = 2'd0;
                    digit_pos_next  = 3'd0;
                    cand_h_next     = 7'd0;
                    cand_m_next     = 7'd0;
                    cand_s_next     = 7'd0;
                    check_next      = 8'd0;
                    check_cnt_next  = 2'd0;
                end
            end else begin
                case (phase_reg)
                    PH_IDLE: begin
                        if (c == nrte_pkg::CH_DOLLAR) begin
                            phase_next      = PH_RMC_PREFIX;
                            prefix_pos_next = 3'd1;
                        end else if (c == nrte_pkg::CH_E) begin
                            phase_next      = PH_END_PREFIX;
                            prefix_pos_next = 3'd1;
                        end else begin
                            phase_next = PH_OTHER;
                        end
                    end
                    PH_RMC_PREFIX: begin
                        if (c == nrte_pkg::rmc_char(prefix_pos_reg)) begin
                            xor_next        = xor_reg ^ c;
                            prefix_pos_next = prefix_pos_reg + 3'd1;
                            if (prefix_pos_next == nrte_pkg::RMC_LEN) begin
                                phase_next = PH_BODY;
                            end
                        end else begin
                            phase_next = PH_OTHER;
                        end
                    end
                    PH_END_PREFIX: begin
                        if (c == nrte_pkg::end_char(prefix_pos_reg)) begin
                            prefix_pos_next = prefix_pos_reg + 3'd1;
                            if (prefix_pos_next == nrte_pkg::END_LEN) begin
                                phase_next = PH_ENDTOK;
                            end
                        end else begin
                            phase_next = PH_OTHER;
                        end
                    end
                    PH_BODY: begin
                        if (c == nrte_pkg::CH_STAR) begin
                            phase_next = PH_CHECK;
                        end else begin
                            xor_next = xor_reg ^ c;
                            if (comma_reg == 2'd2 && c == nrte_pkg::CH_V) begin
                                phase_next = PH_REJECT;
                            end else begin
                                // byte right after the second comma closes the field count
                                if (comma_reg == 2'd2) begin
                                    comma_mid = 2'd3;
                                end
                                if (comma_mid != 2'd0 && digit_pos_reg < 3'd6) begin
                                    digit_pos_next = digit_pos_reg + 3'd1;
                                    if (digit_pos_reg < 3'd2) begin
                                        cand_h_next = slot_new;
                                    end else if (digit_pos_reg < 3'd4) begin
                                        cand_m_next = slot_new;
                                    end else begin
                                        cand_s_next = slot_new;
                                    end
                                end
                                if (c == nrte_pkg::CH_COMMA && comma_mid < 2'd2) begin
                                    comma_next = comma_mid + 2'd1;
                                end else begin
                                    comma_next = comma_mid;
                                end
                            end
                        end
                    end
                    PH_CHECK: begin
                        if (check_cnt_reg < 2'd2) begin
                            if (hex_ok) begin
                                check_next     = {check_reg[3:0], hex_val};
                                check_cnt_next = check_cnt_reg + 2'd1;
                            end else begin
                                check_cnt_next = 2'd3;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            prefix_pos_reg <= 3'd0;
            xor_reg        <= 8'd0;
            comma_reg      <= 2'd0;
            digit_pos_reg  <= 3'd0;
            cand_h_reg     <= 7'd0;
            cand_m_reg     <= 7'd0;
            cand_s_reg     <= 7'd0;
            check_reg      <= 8'd0;
            check_cnt_reg  <= 2'd0;
        end else begin
            phase_reg      <= phase_next;
            prefix_pos_reg <= prefix_pos_next;
            xor_reg        <= xor_next;
            comma_reg      <= comma_next;
            digit_pos_reg  <= digit_pos_next;
            cand_h_reg     <= cand_h_next;
            cand_m_reg     <= cand_m_next;
            cand_s_reg     <= cand_s_next;
            check_reg      <= check_next;
            check_cnt_reg  <= check_cnt_next;
        end
    end

endmodule

// ----- rtl/core/nrte_queue.sv -----
// ----------------------------------------------------------------------------
// nrte_queue
// Two-entry token queue between parser front end and result back end.
// ----------------------------------------------------------------------------
module nrte_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  nrte_pkg::nrte_token_t push_data,
    output logic                  full,
    output logic                  head_valid,
    input  logic                  pop,
    output nrte_pkg::nrte_token_t head_data
);

    nrte_pkg::nrte_token_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/nrte_back.sv -----
// ----------------------------------------------------------------------------
// nrte_back
// Applies zone offset, updates held time and drives the result register.
// ----------------------------------------------------------------------------
module nrte_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [nrte_pkg::ZONE_W-1:0] cfg_wr_data,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  nrte_pkg::nrte_token_t       q_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [nrte_pkg::KIND_W-1:0] m_token_kind,
    output logic [nrte_pkg::HOURS_W-1:0] m_hours,
    output logic [nrte_pkg::TIME_W-1:0] m_minutes,
    output logic [nrte_pkg::TIME_W-1:0] m_seconds
);

    logic [nrte_pkg::ZONE_W-1:0]  zone_reg;
    logic [nrte_pkg::HOURS_W-1:0] held_h_reg, held_h_next;
    logic [nrte_pkg::TIME_W-1:0]  held_m_reg, held_m_next;
    logic [nrte_pkg::TIME_W-1:0]  held_s_reg, held_s_next;
    logic                         valid_reg, valid_next;
    logic [nrte_pkg::KIND_W-1:0]  kind_reg;

    logic [7:0]  sum;
    logic [14:0] recip;
    logic [2:0]  quot;
    logic [7:0]  rem;
    logic [7:0]  rem_fix;

    // sum <= 158; floor(sum/24) == (sum*171) >> 12 over that range
    assign sum     = {1'b0, q_data.hours} + {3'b000, zone_reg};
    assign recip   = {7'd0, sum} * 15'd171;
    assign quot    = recip[14:12];
    assign rem     = sum - ({5'd0, quot} * nrte_pkg::HOURS_PER_DAY);
    assign rem_fix = (rem >= nrte_pkg::HOURS_PER_DAY) ? rem - nrte_pkg::HOURS_PER_DAY : rem;

    assign q_pop = q_valid && (!valid_reg || m_ready);

    always_comb begin
        held_h_next = held_h_reg;
        held_m_next = held_m_reg;
        held_s_next = held_s_reg;
        valid_next  = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (q_pop) begin
            valid_next = 1'b1;
            if (q_data.kind == nrte_pkg::KIND_ACCEPTED) begin
                held_h_next = rem_fix[nrte_pkg::HOURS_W-1:0];
                held_m_next = q_data.minutes;
                held_s_next = q_data.seconds;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg   <= nrte_pkg::ZONE_RESET;
            held_h_reg <= '0;
            held_m_reg <= '0;
            held_s_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                zone_reg <= cfg_wr_data;
            end
            held_h_reg <= held_h_next;
            held_m_reg <= held_m_next;
            held_s_reg <= held_s_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg <= q_data.kind;
        end
    end

    assign m_valid      = valid_reg;
    assign m_token_kind = kind_reg;
    assign m_hours      = held_h_reg;
    assign m_minutes    = held_m_reg;
    assign m_seconds    = held_s_reg;

endmodule

// ----- rtl/core/nmea_rmc_time_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// nmea_rmc_time_extractor_unit
// RMC sentence parser: pulls UTC time out of a character stream, checks the
// sentence checksum and reports one result per whitespace-terminated token.
// ----------------------------------------------------------------------------
//   channel   direction  payload                                   handshake
//   s_        in         char_byte[7:0]                            valid/ready
//   m_        out        token_kind[2:0] hours[4:0] min[6:0] s[6:0] valid/ready
//   cfg_      in         wr_data[4:0] (zone offset hours)          wr_en only
//
// One character per cycle while s_ready is high. A token end is queued at the
// accepting edge and then loads the result register, which drives m_valid,
// once the result side can take it. Synchronous active-low reset; zone offset
// resets to 8, held time to zero.
// s_ready drops only when the two-entry token queue is full, i.e. after the
// result side has been stalled for a while; a waiting result does not block
// the parser.
// ----------------------------------------------------------------------------
module nmea_rmc_time_extractor_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [nrte_pkg::ZONE_W-1:0]  cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [nrte_pkg::CHAR_W-1:0]  s_char_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [nrte_pkg::KIND_W-1:0]  m_token_kind,
    output logic [nrte_pkg::HOURS_W-1:0] m_hours,
    output logic [nrte_pkg::TIME_W-1:0]  m_minutes,
    output logic [nrte_pkg::TIME_W-1:0]  m_seconds
);

    logic                  q_full;
    logic                  q_push;
    nrte_pkg::nrte_token_t q_in;
    logic                  q_valid;
    logic                  q_pop;
    nrte_pkg::nrte_token_t q_out;

    nrte_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_byte (s_char_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    nrte_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .head_valid (q_valid),
        .pop        (q_pop),
        .head_data  (q_out)
    );

    nrte_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_data       (q_out),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_token_kind (m_token_kind),
        .m_hours      (m_hours),
        .m_minutes    (m_minutes),
        .m_seconds    (m_seconds)
    );

endmodule
